FILE: hdl/nbg_pkg.sv
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared constants, types and state codes for the N-body gravity step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbg_pkg;

    localparam int MAX_BODIES = 16;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    localparam int MASS_W = 48;
    localparam int WORD_W = 32;
    localparam int SLOT_W = 4;
    localparam int NBR_W  = 4;
    localparam int ACC_W  = 40;
    localparam int OPND_W = 33;
    localparam int PROD_W = 66;
    localparam int NUM_W  = 96;
    localparam int DEN_W  = 100;
    localparam int QUO_W  = 34;
    localparam int DIV_SH = 34;
    localparam int DSH_W  = DEN_W + DIV_SH;

    localparam logic [WORD_W-1:0] TIME_STEP_RST  = 32'd85899346;
    localparam logic [WORD_W-1:0] GRAV_CONST_RST = 32'd1231106200;
    localparam logic [NBR_W-1:0]  MAX_NBR_RST    = 4'd15;

    localparam logic [1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [1:0] REG_GRAV_CONST = 2'd1;
    localparam logic [1:0] REG_MAX_NBR    = 2'd2;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [2:0][WORD_W-1:0] vec3_t;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        vec3_t             pos;
        vec3_t             vel;
        logic [WORD_W-1:0] rate;
        logic [WORD_W-1:0] spin;
    } body_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef enum logic [5:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_SHIFT, S_SHIFT_WR, S_INS,
        S_TICK_A, S_TICK_A_RES, S_BODY_RD, S_BODY_LD, S_MOVE, S_MOVE_RES,
        S_NBR, S_PAIR, S_SQ, S_SQ_RES, S_CH, S_CH_RES, S_CL, S_CL_RES,
        S_ROOT, S_DL, S_DL_RES, S_DH, S_DH_RES, S_NL, S_NL_RES, S_NH,
        S_NH_RES, S_DIV, S_DIV_RES, S_FIN, S_WAIT
    } state_t;

endpackage

FILE: hdl/nbody_gravity_step.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step
// Direct-sum gravity integrator over a mass-sorted body table, Q16.16.
// Add item: a sorted search for the slot, then the later entries move up a slot.
// Tick item: one product of time step and gravity constant, then per body a
// move and a pass over its neighbours in the shared unit: a 32-step root and
// three 35-step divides per pair, none for a neighbour at zero distance.
// One item at a time; ready only between items. Reset empties the table,
// restores the register defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbody_gravity_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [47:0]         body_mass,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic signed [31:0]  spin_rate,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          slot,
    output logic signed [31:0]  new_pos_x,
    output logic signed [31:0]  new_pos_y,
    output logic signed [31:0]  new_pos_z,
    output logic signed [31:0]  new_vel_x,
    output logic signed [31:0]  new_vel_y,
    output logic signed [31:0]  new_vel_z,
    output logic signed [31:0]  spin_angle,
    output logic                last_body
);

    localparam int CW = nbg_pkg::CNT_W;
    localparam int IW = nbg_pkg::IDX_W;
    localparam int AW = nbg_pkg::ACC_W;

    function automatic logic [31:0] sat32(input logic [nbg_pkg::ACC_W-1:0] v);
        logic fits;
        fits = (&v[nbg_pkg::ACC_W-1:31]) || !(|v[nbg_pkg::ACC_W-1:31]);
        if (fits)
            return v[31:0];
        else if (v[nbg_pkg::ACC_W-1])
            return 32'h8000_0000;
        else
            return 32'h7FFF_FFFF;
    endfunction

    nbg_pkg::state_t state_reg, state_next;
    nbg_pkg::state_t ret_reg, ret_next;

    logic [31:0]       time_step_reg, time_step_next;
    logic [31:0]       grav_const_reg, grav_const_next;
    logic [3:0]        max_nbr_reg, max_nbr_next;
    logic [CW-1:0]     count_reg, count_next;
    nbg_pkg::body_t    new_reg, new_next;
    nbg_pkg::body_t    cur_reg, cur_next;
    logic [CW-1:0]     at_reg, at_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [1:0]        k_reg, k_next;
    logic [31:0]       a_reg, a_next;
    logic [2:0][AW-1:0] acc_reg, acc_next;
    logic [2:0]        dneg_reg, dneg_next;
    logic [2:0][30:0]  e_reg, e_next;
    logic [1:0]        s_reg, s_next;
    logic [47:0]       mass_reg, mass_next;
    logic [63:0]       q_reg, q_next;
    logic [63:0]       c_reg, c_next;
    logic [nbg_pkg::DEN_W-1:0] den_reg, den_next;
    logic [nbg_pkg::NUM_W-1:0] num_reg, num_next;

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_slot_reg, out_slot_next;
    nbg_pkg::vec3_t    out_pos_reg, out_pos_next;
    nbg_pkg::vec3_t    out_vel_reg, out_vel_next;
    logic [31:0]       out_spin_reg, out_spin_next;
    logic              out_last_reg, out_last_next;

    // Shared unit and table ports
    nbg_pkg::arith_ctl_t          actl;
    logic signed [nbg_pkg::OPND_W-1:0] mul_a, mul_b;
    logic                         a_done;
    logic [nbg_pkg::PROD_W-1:0]   prod;
    logic [31:0]                  root;
    logic [nbg_pkg::QUO_W-1:0]    quo;

    logic                ram_wr_en, ram_rd_en;
    logic [IW-1:0]       ram_wr_addr, ram_rd_addr;
    nbg_pkg::body_t      ram_wr_data, ram_rd_data;

    // Pair geometry from the neighbour just read and the current body
    logic [2:0][32:0]    pd;
    logic [2:0][32:0]    pmag;
    logic [2:0][30:0]    pe;
    logic [1:0]          ps;
    logic                pzero;
    logic                pbig1, pbig2;

    always_comb
    begin
        pbig1 = 1'b0;
        pbig2 = 1'b0;
        pzero = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            pd[k] = {ram_rd_data.pos[k][31], ram_rd_data.pos[k]}
                  - {cur_reg.pos[k][31], cur_reg.pos[k]};
            pmag[k] = pd[k][32] ? (33'd0 - pd[k]) : pd[k];
            pbig2 = pbig2 | pmag[k][32];
            pbig1 = pbig1 | pmag[k][32] | pmag[k][31];
            pzero = pzero & (pmag[k] == 33'd0);
        end
        ps = pbig2 ? 2'd2 : (pbig1 ? 2'd1 : 2'd0);
        for (int k = 0; k < 3; k++)
        begin
            pe[k] = 31'(pmag[k] >> ps);
        end
    end

    assign in_ready = (state_reg == nbg_pkg::S_IDLE);

    always_comb
    begin
        logic [33:0]     mv_sum;
        logic [CW-1:0]   idx_dec;
        logic [nbg_pkg::DEN_W-1:0] den_sum;
        logic            out_free;
        nbg_pkg::vec3_t  vel_new;

        state_next      = state_reg;
        ret_next        = ret_reg;
        time_step_next  = time_step_reg;
        grav_const_next = grav_const_reg;
        max_nbr_next    = max_nbr_reg;
        count_next      = count_reg;
        new_next        = new_reg;
        cur_next        = cur_reg;
        at_next         = at_reg;
        idx_next        = idx_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        used_next       = used_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        acc_next        = acc_reg;
        dneg_next       = dneg_reg;
        e_next          = e_reg;
        s_next          = s_reg;
        mass_next       = mass_reg;
        q_next          = q_reg;
        c_next          = c_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_slot_next   = out_slot_reg;
        out_pos_next    = out_pos_reg;
        out_vel_next    = out_vel_reg;
        out_spin_next   = out_spin_reg;
        out_last_next   = out_last_reg;

        actl        = '{start: 1'b0, op: nbg_pkg::OP_MUL};
        mul_a       = '0;
        mul_b       = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = cur_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        idx_dec  = idx_reg - 1'b1;
        mv_sum   = {{2{cur_reg.pos[0][31]}}, cur_reg.pos[0]} + prod[65:32];
        den_sum  = nbg_pkg::DEN_W'(den_reg) + nbg_pkg::DEN_W'({prod[63:0], 32'b0});
        out_free = !out_valid_reg || out_ready;
        for (int k = 0; k < 3; k++)
        begin
            vel_new[k] = sat32(acc_reg[k]);
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                nbg_pkg::REG_TIME_STEP:  time_step_next  = cfg_wdata;
                nbg_pkg::REG_GRAV_CONST: grav_const_next = cfg_wdata;
                nbg_pkg::REG_MAX_NBR:    max_nbr_next    = cfg_wdata[3:0];
                default:                 ;
            endcase
        end

        unique case (state_reg)
            nbg_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == nbg_pkg::MODE_ADD)
                    begin
                        new_next.mass   = body_mass;
                        new_next.pos[0] = pos_x;
                        new_next.pos[1] = pos_y;
                        new_next.pos[2] = pos_z;
                        new_next.vel[0] = vel_x;
                        new_next.vel[1] = vel_y;
                        new_next.vel[2] = vel_z;
                        new_next.rate   = spin_rate;
                        new_next.spin   = '0;
                        at_next         = '0;
                        state_next      = nbg_pkg::S_FIND_RD;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = nbg_pkg::S_TICK_A;
                    end
                end
            end
            nbg_pkg::S_FIND_RD:
            begin
                if (count_reg == CW'(nbg_pkg::MAX_BODIES))
                begin
                    state_next = nbg_pkg::S_IDLE;
                end
                else if (at_reg == count_reg)
                begin
                    idx_next   = count_reg;
                    state_next = nbg_pkg::S_SHIFT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = at_reg[IW-1:0];
                    state_next  = nbg_pkg::S_FIND_CHK;
                end
            end
            nbg_pkg::S_FIND_CHK:
            begin
                // Equal masses keep their order: the new body goes after them.
                if (ram_rd_data.mass >= new_reg.mass)
                begin
                    at_next    = at_reg + 1'b1;
                    state_next = nbg_pkg::S_FIND_RD;
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = nbg_pkg::S_SHIFT;
                end
            end
            nbg_pkg::S_SHIFT:
            begin
                if (idx_reg == at_reg)
                begin
                    state_next = nbg_pkg::S_INS;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_dec[IW-1:0];
                    state_next  = nbg_pkg::S_SHIFT_WR;
                end
            end
            nbg_pkg::S_SHIFT_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg[IW-1:0];
                ram_wr_data = ram_rd_data;
                idx_next    = idx_dec;
                state_next  = nbg_pkg::S_SHIFT;
            end
            nbg_pkg::S_INS:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = at_reg[IW-1:0];
                ram_wr_data = new_reg;
                count_next  = count_reg + 1'b1;
                state_next  = nbg_pkg::S_IDLE;
            end
            nbg_pkg::S_TICK_A:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, time_step_reg});
                mul_b      = $signed({1'b0, grav_const_reg});
                ret_next   = nbg_pkg::S_TICK_A_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_TICK_A_RES:
            begin
                a_next     = prod[63:32];
                state_next = nbg_pkg::S_BODY_RD;
            end
            nbg_pkg::S_BODY_RD:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = nbg_pkg::S_IDLE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = i_reg[IW-1:0];
                    state_next  = nbg_pkg::S_BODY_LD;
                end
            end
            nbg_pkg::S_BODY_LD:
            begin
                cur_next = ram_rd_data;
                for (int k = 0; k < 3; k++)
                begin
                    acc_next[k] = {{(AW-32){ram_rd_data.vel[k][31]}}, ram_rd_data.vel[k]};
                end
                k_next     = 2'd0;
                state_next = nbg_pkg::S_MOVE;
            end
            nbg_pkg::S_MOVE:
            begin
                actl = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                if (k_reg == 2'd3)
                begin
                    mul_a = $signed({cur_reg.rate[31], cur_reg.rate});
                end
                else
                begin
                    mul_a = $signed({cur_reg.vel[k_reg][31], cur_reg.vel[k_reg]});
                end
                mul_b      = $signed({1'b0, time_step_reg});
                ret_next   = nbg_pkg::S_MOVE_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_MOVE_RES:
            begin
                if (k_reg == 2'd3)
                begin
                    cur_next.spin = cur_reg.spin + prod[63:32];
                    j_next        = '0;
                    used_next     = '0;
                    state_next    = nbg_pkg::S_NBR;
                end
                else
                begin
                    mv_sum = {{2{cur_reg.pos[k_reg][31]}}, cur_reg.pos[k_reg]} + prod[65:32];
                    cur_next.pos[k_reg] = sat32({{(AW-34){mv_sum[33]}}, mv_sum});
                    k_next     = k_reg + 2'd1;
                    state_next = nbg_pkg::S_MOVE;
                end
            end
            nbg_pkg::S_NBR:
            begin
                if ((j_reg < count_reg) && (8'(used_reg) <= 8'(max_nbr_reg)))
                begin
                    if (j_reg == i_reg)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        used_next   = used_reg + 1'b1;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = j_reg[IW-1:0];
                        state_next  = nbg_pkg::S_PAIR;
                    end
                end
                else
                begin
                    state_next = nbg_pkg::S_FIN;
                end
            end
            nbg_pkg::S_PAIR:
            begin
                // A neighbour at the same place counts but pulls nothing.
                if (pzero)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = nbg_pkg::S_NBR;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        dneg_next[k] = pd[k][32];
                    end
                    e_next     = pe;
                    s_next     = ps;
                    mass_next  = ram_rd_data.mass;
                    q_next     = '0;
                    k_next     = 2'd0;
                    state_next = nbg_pkg::S_SQ;
                end
            end
            nbg_pkg::S_SQ:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({2'b0, e_reg[k_reg]});
                mul_b      = $signed({2'b0, e_reg[k_reg]});
                ret_next   = nbg_pkg::S_SQ_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_SQ_RES:
            begin
                q_next = q_reg + prod[63:0];
                if (k_reg == 2'd2)
                begin
                    state_next = nbg_pkg::S_CH;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = nbg_pkg::S_SQ;
                end
            end
            nbg_pkg::S_CH:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, a_reg});
                mul_b      = $signed({9'b0, mass_reg[47:24]});
                ret_next   = nbg_pkg::S_CH_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_CH_RES:
            begin
                c_next     = {prod[55:0], 8'b0};
                state_next = nbg_pkg::S_CL;
            end
            nbg_pkg::S_CL:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, a_reg});
                mul_b      = $signed({9'b0, mass_reg[23:0]});
                ret_next   = nbg_pkg::S_CL_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_CL_RES:
            begin
                c_next     = c_reg + {24'b0, prod[55:16]};
                state_next = nbg_pkg::S_ROOT;
            end
            nbg_pkg::S_ROOT:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_SQRT};
                ret_next   = nbg_pkg::S_DL;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_DL:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, q_reg[31:0]});
                mul_b      = $signed({1'b0, root});
                ret_next   = nbg_pkg::S_DL_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_DL_RES:
            begin
                den_next   = nbg_pkg::DEN_W'(prod[63:0]);
                state_next = nbg_pkg::S_DH;
            end
            nbg_pkg::S_DH:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, q_reg[63:32]});
                mul_b      = $signed({1'b0, root});
                ret_next   = nbg_pkg::S_DH_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_DH_RES:
            begin
                // The scale shift on the axes comes back squared in the cube.
                den_next   = den_sum << {s_reg, 1'b0};
                k_next     = 2'd0;
                state_next = nbg_pkg::S_NL;
            end
            nbg_pkg::S_NL:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, c_reg[31:0]});
                mul_b      = $signed({2'b0, e_reg[k_reg]});
                ret_next   = nbg_pkg::S_NL_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_NL_RES:
            begin
                num_next   = nbg_pkg::NUM_W'(prod[63:0]);
                state_next = nbg_pkg::S_NH;
            end
            nbg_pkg::S_NH:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_MUL};
                mul_a      = $signed({1'b0, c_reg[63:32]});
                mul_b      = $signed({2'b0, e_reg[k_reg]});
                ret_next   = nbg_pkg::S_NH_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_NH_RES:
            begin
                num_next   = num_reg + {prod[63:0], 32'b0};
                state_next = nbg_pkg::S_DIV;
            end
            nbg_pkg::S_DIV:
            begin
                actl       = '{start: 1'b1, op: nbg_pkg::OP_DIV};
                ret_next   = nbg_pkg::S_DIV_RES;
                state_next = nbg_pkg::S_WAIT;
            end
            nbg_pkg::S_DIV_RES:
            begin
                if (dneg_reg[k_reg])
                begin
                    acc_next[k_reg] = acc_reg[k_reg] - AW'(quo);
                end
                else
                begin
                    acc_next[k_reg] = acc_reg[k_reg] + AW'(quo);
                end
                if (k_reg == 2'd2)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = nbg_pkg::S_NBR;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = nbg_pkg::S_NL;
                end
            end
            nbg_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = i_reg[IW-1:0];
                    ram_wr_data      = cur_reg;
                    ram_wr_data.vel  = vel_new;
                    out_valid_next   = 1'b1;
                    out_slot_next    = 4'(i_reg);
                    out_pos_next     = cur_reg.pos;
                    out_vel_next     = vel_new;
                    out_spin_next    = cur_reg.spin;
                    out_last_next    = ((i_reg + 1'b1) == count_reg);
                    i_next           = i_reg + 1'b1;
                    state_next       = nbg_pkg::S_BODY_RD;
                end
            end
            nbg_pkg::S_WAIT:
            begin
                if (a_done)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = nbg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nbg_pkg::S_IDLE;
            ret_reg        <= nbg_pkg::S_IDLE;
            time_step_reg  <= nbg_pkg::TIME_STEP_RST;
            grav_const_reg <= nbg_pkg::GRAV_CONST_RST;
            max_nbr_reg    <= nbg_pkg::MAX_NBR_RST;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            time_step_reg  <= time_step_next;
            grav_const_reg <= grav_const_next;
            max_nbr_reg    <= max_nbr_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg      <= new_next;
        cur_reg      <= cur_next;
        at_reg       <= at_next;
        idx_reg      <= idx_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        used_reg     <= used_next;
        k_reg        <= k_next;
        a_reg        <= a_next;
        acc_reg      <= acc_next;
        dneg_reg     <= dneg_next;
        e_reg        <= e_next;
        s_reg        <= s_next;
        mass_reg     <= mass_next;
        q_reg        <= q_next;
        c_reg        <= c_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        out_slot_reg <= out_slot_next;
        out_pos_reg  <= out_pos_next;
        out_vel_reg  <= out_vel_next;
        out_spin_reg <= out_spin_next;
        out_last_reg <= out_last_next;
    end

    nbg_arith u_arith
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (actl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .sqrt_x  (q_reg),
        .div_num (num_reg),
        .div_den (den_reg),
        .done    (a_done),
        .prod    (prod),
        .root    (root),
        .quo     (quo)
    );

    nbg_body_ram u_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign slot       = out_slot_reg;
    assign new_pos_x  = out_pos_reg[0];
    assign new_pos_y  = out_pos_reg[1];
    assign new_pos_z  = out_pos_reg[2];
    assign new_vel_x  = out_vel_reg[0];
    assign new_vel_y  = out_vel_reg[1];
    assign new_vel_z  = out_vel_reg[2];
    assign spin_angle = out_spin_reg;
    assign last_body  = out_last_reg;

endmodule

FILE: hdl/nbg_body_ram.sv
// ----------------------------------------------------------------------------
// nbg_body_ram
// Body record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbg_body_ram
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [nbg_pkg::IDX_W-1:0] wr_addr,
    input  nbg_pkg::body_t          wr_data,
    input  logic                    rd_en,
    input  logic [nbg_pkg::IDX_W-1:0] rd_addr,
    output nbg_pkg::body_t          rd_data
);

    nbg_pkg::body_t mem [nbg_pkg::MAX_BODIES];
    nbg_pkg::body_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/nbg_arith.sv
// ----------------------------------------------------------------------------
// nbg_arith
// Shared arithmetic unit: registered 33x33 multiply, bit-serial square root
// and bit-serial capped division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbg_arith
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  nbg_pkg::arith_ctl_t                ctl,
    input  logic signed [nbg_pkg::OPND_W-1:0]  mul_a,
    input  logic signed [nbg_pkg::OPND_W-1:0]  mul_b,
    input  logic [63:0]                        sqrt_x,
    input  logic [nbg_pkg::NUM_W-1:0]          div_num,
    input  logic [nbg_pkg::DEN_W-1:0]          div_den,
    output logic                               done,
    output logic [nbg_pkg::PROD_W-1:0]         prod,
    output logic [31:0]                        root,
    output logic [nbg_pkg::QUO_W-1:0]          quo
);

    localparam logic [nbg_pkg::QUO_W-1:0] QUO_CAP = nbg_pkg::QUO_W'(64'h2_0000_0000);
    localparam logic [5:0] DIV_FIRST = 6'(nbg_pkg::DIV_SH);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    nbg_pkg::arith_op_t          op_reg, op_next;
    logic [nbg_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [63:0]                 x_reg, x_next;
    logic [63:0]                 res_reg, res_next;
    logic [63:0]                 bit_reg, bit_next;
    logic [nbg_pkg::NUM_W-1:0]   rem_reg, rem_next;
    logic [nbg_pkg::DSH_W-1:0]   dsh_reg, dsh_next;
    logic [nbg_pkg::QUO_W-1:0]   q_reg, q_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        cap_reg, cap_next;

    logic signed [nbg_pkg::PROD_W-1:0] prod_calc;
    logic [63:0]                 trial;
    logic                        ge;

    assign prod_calc = mul_a * mul_b;
    assign trial     = res_reg + bit_reg;
    assign ge        = nbg_pkg::DSH_W'(rem_reg) >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        prod_next = prod_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        cap_next  = cap_reg;
        if (ctl.start)
        begin
            op_next = ctl.op;
            unique case (ctl.op)
                nbg_pkg::OP_MUL:
                begin
                    prod_next = prod_calc;
                    done_next = 1'b1;
                end
                nbg_pkg::OP_SQRT:
                begin
                    x_next    = sqrt_x;
                    res_next  = '0;
                    bit_next  = 64'h4000_0000_0000_0000;
                    busy_next = 1'b1;
                end
                nbg_pkg::OP_DIV:
                begin
                    rem_next  = div_num;
                    dsh_next  = {div_den, {nbg_pkg::DIV_SH{1'b0}}};
                    q_next    = '0;
                    cnt_next  = DIV_FIRST;
                    cap_next  = 1'b0;
                    busy_next = 1'b1;
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                nbg_pkg::OP_SQRT:
                begin
                    if (x_reg >= trial)
                    begin
                        x_next   = x_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                    if (bit_reg == 64'd1)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                nbg_pkg::OP_DIV:
                begin
                    dsh_next = dsh_reg >> 1;
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == DIV_FIRST)
                    begin
                        // A quotient at or above two to the 34th is capped at once.
                        if (ge)
                        begin
                            cap_next  = 1'b1;
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (ge)
                        begin
                            rem_next = rem_reg - dsh_reg[nbg_pkg::NUM_W-1:0];
                        end
                        q_next = {q_reg[nbg_pkg::QUO_W-2:0], ge};
                        if (cnt_reg == 6'd0)
                        begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= nbg_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        cap_reg  <= cap_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;
    assign root = res_reg[31:0];
    assign quo  = (cap_reg || (q_reg > QUO_CAP)) ? QUO_CAP : q_reg;

endmodule

FILE: hdl/nbg_checker.sv
// ----------------------------------------------------------------------------
// nbg_checker
// Port-level checks for the N-body gravity step block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] slot,
    input logic       last_body
);

    // A waiting result item holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(last_body))
        else $error("result item changed while stalled");

    // While a tick still has bodies to report, no new item is taken.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_body |-> !in_ready)
        else $error("ready during an unfinished tick");

    // Ready is low in the cycle after an item is accepted.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready straight after an accepted item");

endmodule

bind nbody_gravity_step nbg_checker u_nbg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot      (slot),
    .last_body (last_body)
);

FILE: tb/sv/tb_nbody_gravity_step.sv
// ----------------------------------------------------------------------------
// tb_nbody_gravity_step
// Self-checking bench for the N-body gravity step block. A bit-exact predictor
// follows every accepted item and queues the body results that a tick must
// give. Each result taken from the block is compared field by field with the
// oldest one queued. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nbody_gravity_step;

    localparam longint     CYCLE_LIMIT = 20000000;
    localparam int         SETTLE_CYC  = 400;
    localparam logic [1:0] REG_NONE    = 2'd3;

    typedef struct {
        logic        mode;
        logic [47:0] mass;
        logic [31:0] px, py, pz, vx, vy, vz, rate;
    } body_item_t;

    typedef struct {
        logic [3:0]  slot;
        logic [31:0] px, py, pz, vx, vy, vz, spin;
        logic        last;
    } body_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [47:0] body_mass;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_rate;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  slot;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z, spin_angle;
    logic        last_body;

    nbody_gravity_step uut (.*);

    // Predictor state
    logic [31:0] dt_q;
    logic [31:0] g_scaled;
    logic [3:0]  nbr_cap;
    logic [47:0] p_mass [nbg_pkg::MAX_BODIES];
    longint      p_pos  [nbg_pkg::MAX_BODIES][3];
    longint      p_vel  [nbg_pkg::MAX_BODIES][3];
    longint      p_rate [nbg_pkg::MAX_BODIES];
    logic [31:0] p_spin [nbg_pkg::MAX_BODIES];
    int          n_bodies;

    body_result_t pending_bodies[$];
    int           errors;
    longint       cycles;
    bit           quiet;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor(v * dt / 2^32); an arithmetic shift rounds towards minus infinity.
    function automatic longint dt_scaled(longint v);
        longint prod;
        prod = v * longint'({32'd0, dt_q});
        return prod >>> 32;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Pull of body j on body i, added into acc.
    task automatic add_gravity(input int i, input int j, inout longint acc[3]);
        longint       d [3];
        logic [63:0]  mag [3];
        logic [63:0]  e, amax, q, r, a, c;
        logic [127:0] den, num, quo;
        int           s;
        amax = 0;
        q = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = p_pos[j][k] - p_pos[i][k];
            mag[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            if (mag[k] > amax)
                amax = mag[k];
        end
        if (amax == 0)
            return;
        while ((amax >> s) >= 64'h8000_0000)
            s++;
        for (int k = 0; k < 3; k++)
        begin
            e = mag[k] >> s;
            q = q + e * e;
        end
        r = floor_sqrt(q);
        a = (64'(dt_q) * 64'(g_scaled)) >> 32;
        c = ((a * 64'(p_mass[j][47:24])) << 8) + ((a * 64'(p_mass[j][23:0])) >> 16);
        den = (128'(q) * 128'(r)) << (2 * s);
        for (int k = 0; k < 3; k++)
        begin
            num = 128'(c) * 128'(mag[k] >> s);
            quo = num / den;
            if (quo > (128'd1 << 33))
                quo = 128'd1 << 33;
            acc[k] += d[k] < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        end
    endtask

    task automatic predict_item(input body_item_t it);
        int           at;
        int           used;
        longint       acc [3];
        body_result_t res;
        if (it.mode == nbg_pkg::MODE_ADD)
        begin
            if (n_bodies >= nbg_pkg::MAX_BODIES)
                return;
            at = 0;
            while (at < n_bodies && p_mass[at] >= it.mass)
                at++;
            for (int i = n_bodies; i > at; i--)
            begin
                p_mass[i] = p_mass[i-1];
                p_rate[i] = p_rate[i-1];
                p_spin[i] = p_spin[i-1];
                p_pos[i] = p_pos[i-1];
                p_vel[i] = p_vel[i-1];
            end
            p_mass[at] = it.mass;
            p_pos[at][0] = longint'($signed(it.px));
            p_pos[at][1] = longint'($signed(it.py));
            p_pos[at][2] = longint'($signed(it.pz));
            p_vel[at][0] = longint'($signed(it.vx));
            p_vel[at][1] = longint'($signed(it.vy));
            p_vel[at][2] = longint'($signed(it.vz));
            p_rate[at] = longint'($signed(it.rate));
            p_spin[at] = 32'd0;
            n_bodies++;
            return;
        end
        for (int i = 0; i < n_bodies; i++)
        begin
            used = 0;
            for (int k = 0; k < 3; k++)
                p_pos[i][k] = sat32(p_pos[i][k] + dt_scaled(p_vel[i][k]));
            p_spin[i] = p_spin[i] + 32'(dt_scaled(p_rate[i]));
            acc = p_vel[i];
            for (int j = 0; j < n_bodies && used <= int'(nbr_cap); j++)
            begin
                if (j == i)
                    continue;
                used++;
                add_gravity(i, j, acc);
            end
            for (int k = 0; k < 3; k++)
                p_vel[i][k] = sat32(acc[k]);
            res.slot = 4'(i);
            res.px = 32'(p_pos[i][0]);
            res.py = 32'(p_pos[i][1]);
            res.pz = 32'(p_pos[i][2]);
            res.vx = 32'(p_vel[i][0]);
            res.vy = 32'(p_vel[i][1]);
            res.vz = 32'(p_vel[i][2]);
            res.spin = p_spin[i];
            res.last = (i + 1 == n_bodies);
            pending_bodies.insert(pending_bodies.size(), res);
        end
    endtask

    function automatic int draw_wait();
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Called right after an acceptance edge or from idle; drives at falling edges.
    task automatic send_item(input body_item_t it);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode = it.mode;
        body_mass = it.mass;
        pos_x = it.px;
        pos_y = it.py;
        pos_z = it.pz;
        vel_x = it.vx;
        vel_y = it.vy;
        vel_z = it.vz;
        spin_rate = it.rate;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_item(it);
    endtask

    // Drop valid, wait for every queued result and let trailing work finish.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_bodies.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == nbg_pkg::REG_TIME_STEP)
            dt_q = val;
        else if (idx == nbg_pkg::REG_GRAV_CONST)
            g_scaled = val;
        else if (idx == nbg_pkg::REG_MAX_NBR)
            nbr_cap = val[3:0];
    endtask

    function automatic body_item_t make_body(logic [47:0] m, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [31:0] u, logic [31:0] v,
                                             logic [31:0] w, logic [31:0] rt);
        body_item_t it;
        it.mode = nbg_pkg::MODE_ADD;
        it.mass = m;
        it.px = x;
        it.py = y;
        it.pz = z;
        it.vx = u;
        it.vy = v;
        it.vz = w;
        it.rate = rt;
        return it;
    endfunction

    function automatic body_item_t make_tick();
        body_item_t it;
        it = make_body(48'({$urandom, $urandom}), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        it.mode = nbg_pkg::MODE_TICK;
        return it;
    endfunction

    // Either anywhere in the range, or close to the origin so that pulls stay
    // below the cap and do not saturate at once.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    function automatic body_item_t rand_body();
        logic [47:0] m;
        case ($urandom_range(0, 3))
            0: m = 48'({$urandom, $urandom});
            1: m = 48'($urandom_range(0, 1000));
            default: m = {16'($urandom_range(0, 4096)), $urandom};
        endcase
        return make_body(m, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), $urandom);
    endfunction

    // Receiver: stall a random number of cycles before each result.
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            n = draw_wait();
            if (n > 0)
            begin
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && rst_n));
        end
    end

    always @(posedge clk)
    begin
        body_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bodies.size() == 0)
            begin
                $display("%0t: unexpected result slot %0d", $time, slot);
                errors++;
            end
            else
            begin
                exp_r = pending_bodies[0];
                pending_bodies.delete(0);
                if ({slot, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                     new_vel_z, spin_angle, last_body} !==
                    {exp_r.slot, exp_r.px, exp_r.py, exp_r.pz, exp_r.vx, exp_r.vy,
                     exp_r.vz, exp_r.spin, exp_r.last})
                begin
                    $display("%0t: expected slot %0d pos %h %h %h vel %h %h %h spin %h last %b",
                             $time, exp_r.slot, exp_r.px, exp_r.py, exp_r.pz,
                             exp_r.vx, exp_r.vy, exp_r.vz, exp_r.spin, exp_r.last);
                    $display("%0t: actual   slot %0d pos %h %h %h vel %h %h %h spin %h last %b",
                             $time, slot, new_pos_x, new_pos_y, new_pos_z,
                             new_vel_x, new_vel_y, new_vel_z, spin_angle, last_body);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_tick();
        send_item(make_tick());
        send_item(make_tick());
        settle();
    endtask

    // Extremes of every field, equal masses, zero mass and a coincident pair.
    task automatic test_directed_bodies();
        write_reg(nbg_pkg::REG_MAX_NBR, 32'hFFFF_FFF3);
        send_item(make_body(48'hFFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                            32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0000_0000, 32'h7FFF_FFFF));
        send_item(make_body(48'd0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                            32'h0, 32'h0, 32'h0, 32'h8000_0000));
        send_item(make_body(48'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h1));
        send_item(make_body(48'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // Same position as the heaviest body: a zero-distance neighbour.
        send_item(make_body(48'h0000_0100_0000, 32'h0, 32'h0, 32'h0,
                            32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_body(48'h0000_1234_5678, 32'h0002_8000, 32'hFFFE_0000,
                            32'h0000_4000, 32'h0, 32'h0, 32'h0, 32'h0003_0000));
        send_item(make_tick());
        send_item(make_tick());
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(nbg_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
        write_reg(nbg_pkg::REG_GRAV_CONST, 32'hFFFF_FFFF);
        write_reg(nbg_pkg::REG_MAX_NBR, 32'd0);
        send_item(make_tick());
        settle();
        write_reg(nbg_pkg::REG_TIME_STEP, 32'd0);
        write_reg(nbg_pkg::REG_GRAV_CONST, 32'd0);
        write_reg(nbg_pkg::REG_MAX_NBR, 32'd15);
        send_item(make_tick());
        settle();
        // An index past the last register must change nothing.
        write_reg(REG_NONE, 32'h0000_0001);
        write_reg(nbg_pkg::REG_TIME_STEP, 32'd85899346);
        write_reg(nbg_pkg::REG_GRAV_CONST, 32'h4000_0000);
        write_reg(nbg_pkg::REG_MAX_NBR, 32'd1);
        send_item(make_tick());
        settle();
    endtask

    // Fills the table, overfills it, and ticks under a few register settings.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(nbg_pkg::REG_TIME_STEP, phase == 4 ? 32'hFFFF_FFFF : $urandom);
            write_reg(nbg_pkg::REG_GRAV_CONST, $urandom);
            write_reg(nbg_pkg::REG_MAX_NBR,
                      phase == 2 ? 32'd15 : 32'($urandom_range(0, 2)));
            quiet = (phase == 1);
            for (int n = 0; n < (phase == 2 ? 3 : 22); )
            begin
                if (n_bodies < nbg_pkg::MAX_BODIES && $urandom_range(0, 9) < 6)
                begin
                    send_item(rand_body());
                    n++;
                end
                else if (n_bodies == nbg_pkg::MAX_BODIES && $urandom_range(0, 9) == 0)
                    send_item(rand_body());
                else
                begin
                    send_item(make_tick());
                    n++;
                end
            end
            settle();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        n_bodies = 0;
        dt_q = nbg_pkg::TIME_STEP_RST;
        g_scaled = nbg_pkg::GRAV_CONST_RST;
        nbr_cap = nbg_pkg::MAX_NBR_RST;
        cfg_wr_en = 1'b0;
        cfg_addr = nbg_pkg::REG_TIME_STEP;
        cfg_wdata = 32'd0;
        in_valid = 1'b0;
        mode = nbg_pkg::MODE_ADD;
        body_mass = 48'd0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        vel_x = 0;
        vel_y = 0;
        vel_z = 0;
        spin_rate = 0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_empty_tick();
        test_directed_bodies();
        test_register_extremes();
        test_random_traffic();

        if (errors == 0 && pending_bodies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
